FILE: design/binned_msd_accumulator_macros.svh
// Assertion macros for the binned MSD accumulator back end.
`ifndef BINNED_MSD_ACCUMULATOR_MACROS_SVH
`define BINNED_MSD_ACCUMULATOR_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BMSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent on the next edge.
`define BMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bmsd_pkg.sv
// Shared constants and types for the binned MSD accumulator.
package bmsd_pkg;

    localparam int DEF_MAX_LAYERS  = 16;
    localparam int DEF_MAX_LAGS    = 64;
    localparam int DEF_MAX_SPECIES = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MASK   = 2'd1;

    localparam logic [4:0] LAYER_COUNT_RST = 5'd1;
    localparam logic [2:0] AXIS_MASK_RST   = 3'd7;

    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam int MAG_W = 33;

    // Flags of one queued transaction.
    typedef struct packed {
        logic req;
        logic bad;
    } t_item_flags;

    // Status from the back end to the front end.
    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_stat;

endpackage

FILE: design/bmsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/bmsd_front.sv
// Front end: configuration, request classification and the transaction queue.
module bmsd_front #(
    parameter int MAX_LAYERS  = bmsd_pkg::DEF_MAX_LAYERS,
    parameter int MAX_LAGS    = bmsd_pkg::DEF_MAX_LAGS,
    parameter int MAX_SPECIES = bmsd_pkg::DEF_MAX_SPECIES,
    parameter int ADDR_W      = $clog2(MAX_LAYERS * MAX_LAGS * MAX_SPECIES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bmsd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_req_type,
    input  logic [5:0]                          i_lag_index,
    input  logic [3:0]                          i_species,
    input  logic signed [15:0]                  i_start_layer,
    input  logic signed [15:0]                  i_end_layer,
    input  logic [3:0]                          i_bin_layer,
    input  logic signed [31:0]                  i_start_x,
    input  logic signed [31:0]                  i_start_y,
    input  logic signed [31:0]                  i_start_z,
    input  logic signed [31:0]                  i_end_x,
    input  logic signed [31:0]                  i_end_y,
    input  logic signed [31:0]                  i_end_z,
    input  bmsd_pkg::t_back_stat                i_stat,
    output logic                                o_q_valid,
    output bmsd_pkg::t_item_flags               o_q_flags,
    output logic [ADDR_W-1:0]                   o_q_addr,
    output logic [2:0][bmsd_pkg::MAG_W-1:0]     o_q_mag
);
    import bmsd_pkg::*;

    logic [4:0]        r_layer_count;
    logic [2:0]        r_axis_mask;
    t_item_flags       r_q_flags [2];
    logic [ADDR_W-1:0] r_q_addr  [2];
    logic [2:0][MAG_W-1:0] r_q_mag [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    logic              lay_ok;
    logic              spec_ok;
    logic              lag_ok;
    logic              rlay_ok;
    logic              keep;
    logic              push;
    logic [31:0]       layer_sel;
    logic [31:0]       addr_full;
    logic signed [32:0] d [3];
    logic [2:0][MAG_W-1:0] mag;
    t_item_flags       flags;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= LAYER_COUNT_RST;
            r_axis_mask   <= AXIS_MASK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LAYER_COUNT: r_layer_count <= i_cfg_data[4:0];
                CFG_AXIS_MASK:   r_axis_mask   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lay_ok  = (i_start_layer == i_end_layer) && !i_start_layer[15]
                  && ({1'b0, i_start_layer[14:0]} < {11'd0, r_layer_count})
                  && ({17'd0, i_start_layer[14:0]} < 32'(MAX_LAYERS));
        spec_ok = (i_species != 4'd0) && ({28'd0, i_species} <= 32'(MAX_SPECIES));
        lag_ok  = {26'd0, i_lag_index} < 32'(MAX_LAGS);
        rlay_ok = {28'd0, i_bin_layer} < 32'(MAX_LAYERS);
        layer_sel = (i_req_type == REQ_READ) ? {28'd0, i_bin_layer}
                                             : {17'd0, i_start_layer[14:0]};
        addr_full = (layer_sel * 32'(MAX_LAGS) + {26'd0, i_lag_index}) * 32'(MAX_SPECIES)
                    + {28'd0, i_species} - 32'd1;
        // Drop accumulates that name no bin; reads always produce a result.
        keep = (i_req_type == REQ_READ) || (lay_ok && spec_ok && lag_ok);
        flags.req = i_req_type;
        flags.bad = !(spec_ok && lag_ok && rlay_ok);
        d[0] = 33'(i_end_x) - 33'(i_start_x);
        d[1] = 33'(i_end_y) - 33'(i_start_y);
        d[2] = 33'(i_end_z) - 33'(i_start_z);
        for (int k = 0; k < 3; k++) begin
            if (!r_axis_mask[k]) begin
                mag[k] = '0;
            end else if (d[k][32]) begin
                mag[k] = MAG_W'(-d[k]);
            end else begin
                mag[k] = MAG_W'(d[k]);
            end
        end
    end

    assign o_ready = (r_cnt != 2'd2) && !i_stat.clearing;
    assign push    = i_valid && o_ready && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_stat.pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_stat.pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_flags[r_wp] <= flags;
            r_q_addr[r_wp]  <= addr_full[ADDR_W-1:0];
            r_q_mag[r_wp]   <= mag;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_flags = r_q_flags[r_rp];
    assign o_q_addr  = r_q_addr[r_rp];
    assign o_q_mag   = r_q_mag[r_rp];
endmodule

FILE: design/bmsd_back.sv
// Back end: bin clearing, read-modify-write accumulate and mean division.
module bmsd_back #(
    parameter int MAX_LAYERS  = bmsd_pkg::DEF_MAX_LAYERS,
    parameter int MAX_LAGS    = bmsd_pkg::DEF_MAX_LAGS,
    parameter int MAX_SPECIES = bmsd_pkg::DEF_MAX_SPECIES,
    parameter int DEPTH       = MAX_LAYERS * MAX_LAGS * MAX_SPECIES,
    parameter int ADDR_W      = $clog2(DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  bmsd_pkg::t_item_flags           i_q_flags,
    input  logic [ADDR_W-1:0]               i_q_addr,
    input  logic [2:0][bmsd_pkg::MAG_W-1:0] i_q_mag,
    output bmsd_pkg::t_back_stat            o_stat,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [63:0]                     o_mean_sq_disp,
    output logic [31:0]                     o_sample_count,
    output logic                            o_empty_bin
);
    import bmsd_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]            r_state;
    logic [ADDR_W-1:0]     r_clr;
    logic [ADDR_W-1:0]     r_addr;
    t_item_flags           r_flags;
    logic [2:0][MAG_W-1:0] r_mag;
    logic [1:0]            r_ax;
    logic [2*MAG_W-1:0]    r_prod;
    logic [50:0]           r_acc;
    logic [63:0]           r_sum;
    logic [31:0]           r_cnt;
    logic [63:0]           r_quot;
    logic [32:0]           r_rem;
    logic [5:0]            r_step;
    logic [63:0]           r_mean;
    logic                  r_empty;

    logic                  pop;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [63:0]           wsum;
    logic [31:0]           wcnt;
    logic [63:0]           rsum;
    logic [31:0]           rcnt;
    logic [64:0]           sum_ext;
    logic [32:0]           rem_sh;
    logic [32:0]           rem_sub;

    assign pop = (r_state == S_IDLE) && i_q_valid;
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.pop      = pop;

    assign sum_ext = {1'b0, r_sum} + {14'd0, r_acc};
    assign we      = (r_state == S_CLEAR) || (r_state == S_WR);
    assign waddr   = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign wsum    = (r_state == S_CLEAR) ? 64'd0
                   : (sum_ext[64] ? {64{1'b1}} : sum_ext[63:0]);
    assign wcnt    = (r_state == S_CLEAR) ? 32'd0
                   : ((r_cnt == {32{1'b1}}) ? r_cnt : r_cnt + 32'd1);

    assign rem_sh  = {r_rem[31:0], r_quot[63]};
    assign rem_sub = rem_sh - {1'b0, r_cnt};

    bmsd_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wsum),
        .i_raddr (i_q_addr),
        .o_rdata (rsum)
    );

    bmsd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wcnt),
        .i_raddr (i_q_addr),
        .o_rdata (rcnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_flags.req == REQ_ACCUM) begin
                        r_state <= S_SQ;
                    end else if (r_flags.bad || rcnt == 32'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_SQ: begin
                    if (r_ax == 2'd3) begin
                        r_state <= S_WR;
                    end
                end
                S_WR:  r_state <= S_IDLE;
                S_DIV: begin
                    if (r_step == 6'd63) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_addr  <= i_q_addr;
                r_flags <= i_q_flags;
                r_mag   <= i_q_mag;
            end
            S_LOAD: begin
                r_sum   <= rsum;
                r_cnt   <= r_flags.bad ? 32'd0 : rcnt;
                r_quot  <= rsum;
                r_rem   <= '0;
                r_step  <= '0;
                r_ax    <= '0;
                r_acc   <= '0;
                r_mean  <= '0;
                r_empty <= r_flags.bad || rcnt == 32'd0;
            end
            S_SQ: begin
                // One axis squared per cycle; add the previous product.
                if (r_ax != 2'd3) begin
                    r_prod <= r_mag[r_ax] * r_mag[r_ax];
                end
                if (r_ax != 2'd0) begin
                    r_acc <= r_acc + {1'b0, r_prod[65:16]};
                end
                r_ax <= r_ax + 2'd1;
            end
            S_DIV: begin
                // One quotient bit per cycle, restoring.
                if (!rem_sub[32]) begin
                    r_rem  <= rem_sub;
                    r_quot <= {r_quot[62:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_quot <= {r_quot[62:0], 1'b0};
                end
                r_step <= r_step + 6'd1;
                if (r_step == 6'd63) begin
                    r_mean <= {r_quot[62:0], !rem_sub[32]};
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_mean_sq_disp = r_mean;
    assign o_sample_count = r_cnt;
    assign o_empty_bin    = r_empty;

`include "binned_msd_accumulator_macros.svh"

    `BMSD_ASSERT(a_no_pop_in_clear, (r_state == S_CLEAR) |-> !pop, "pop during clearing pass")
    `BMSD_ASSERT(a_we_states, we |-> (r_state == S_CLEAR || r_state == S_WR), "stray bin write")
    `BMSD_ASSERT(a_empty_zero, (o_valid && o_empty_bin) |-> (o_mean_sq_disp == 64'd0), "empty bin mean not zero")
    `BMSD_ASSERT_NEXT(a_wr_done, r_state == S_WR, r_state == S_IDLE, "write not followed by idle")
endmodule

FILE: design/binned_msd_accumulator.sv
// Top level of the binned mean squared displacement accumulator.
// Keeps a 64-bit saturating sum and 32-bit saturating count for each
// (layer, lag, species) bin, held in two RAMs of MAX_LAYERS*MAX_LAGS*MAX_SPECIES
// entries (8192 by default). After reset a clearing pass, during which no request
// transaction is taken, zeroes one bin per cycle; configuration writes are
// always taken. A front end classifies requests, drops accumulates that name
// no bin, and queues up to two transactions; the back end works on one
// transaction at a time. An accumulate in the back end goes through queue pop,
// bin read, three axis squares through one shared 33x33 multiplier plus one
// add, and the bin write. A read of an empty or invalid bin goes from queue
// pop and bin read straight to its result; a read of a filled bin first runs
// the one-bit-per-cycle 64-bit divider. The result stays in the output
// register until taken.
module binned_msd_accumulator #(
    parameter int MAX_LAYERS  = bmsd_pkg::DEF_MAX_LAYERS,
    parameter int MAX_LAGS    = bmsd_pkg::DEF_MAX_LAGS,
    parameter int MAX_SPECIES = bmsd_pkg::DEF_MAX_SPECIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bmsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_req_type,
    input  logic [5:0]                      i_lag_index,
    input  logic [3:0]                      i_species,
    input  logic signed [15:0]              i_start_layer,
    input  logic signed [15:0]              i_end_layer,
    input  logic [3:0]                      i_bin_layer,
    input  logic signed [31:0]              i_start_x,
    input  logic signed [31:0]              i_start_y,
    input  logic signed [31:0]              i_start_z,
    input  logic signed [31:0]              i_end_x,
    input  logic signed [31:0]              i_end_y,
    input  logic signed [31:0]              i_end_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [63:0]                     o_mean_sq_disp,
    output logic [31:0]                     o_sample_count,
    output logic                            o_empty_bin
);
    import bmsd_pkg::*;

    localparam int DEPTH  = MAX_LAYERS * MAX_LAGS * MAX_SPECIES;
    localparam int ADDR_W = $clog2(DEPTH);

    // Queue head handed from front to back; back reports clearing and pops.
    logic                  q_valid;
    t_item_flags           q_flags;
    logic [ADDR_W-1:0]     q_addr;
    logic [2:0][MAG_W-1:0] q_mag;
    t_back_stat            stat;

    bmsd_front #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_LAGS    (MAX_LAGS),
        .MAX_SPECIES (MAX_SPECIES),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_lag_index   (i_lag_index),
        .i_species     (i_species),
        .i_start_layer (i_start_layer),
        .i_end_layer   (i_end_layer),
        .i_bin_layer   (i_bin_layer),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_start_z     (i_start_z),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_end_z       (i_end_z),
        .i_stat        (stat),
        .o_q_valid     (q_valid),
        .o_q_flags     (q_flags),
        .o_q_addr      (q_addr),
        .o_q_mag       (q_mag)
    );

    bmsd_back #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_LAGS    (MAX_LAGS),
        .MAX_SPECIES (MAX_SPECIES),
        .DEPTH       (DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_flags      (q_flags),
        .i_q_addr       (q_addr),
        .i_q_mag        (q_mag),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mean_sq_disp (o_mean_sq_disp),
        .o_sample_count (o_sample_count),
        .o_empty_bin    (o_empty_bin)
    );
endmodule
